// ----- hw/rtl/fenced_page_linear_suballocator_top_assert.svh -----
// ----------------------------------------------------------------------------
// fenced page linear suballocator assertion macros
// shared assertion forms for the suballocator top level
// ----------------------------------------------------------------------------
`ifndef FENCED_PAGE_LINEAR_SUBALLOCATOR_TOP_ASSERT_SVH
`define FENCED_PAGE_LINEAR_SUBALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk and off during reset
`define FPLS_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk and off during reset
`define FPLS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fpls_pkg.sv -----
// ----------------------------------------------------------------------------
// fpls_pkg
// widths, command and status codes for the fenced page suballocator
// ----------------------------------------------------------------------------
package fpls_pkg;

    localparam int unsigned SIZE_W     = 32;
    localparam int unsigned ALOG_W     = 5;
    localparam int unsigned FENCE_IN_W = 64;
    localparam int unsigned PSIZE_W    = 25;
    localparam int unsigned ASIZE_W    = 33;
    localparam int unsigned PAGE_ID_W  = 6;
    localparam int unsigned STATUS_W   = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_CLEANUP = 1'b1;

    localparam t_status STAT_OK        = 2'd0;
    localparam t_status STAT_TOO_LARGE = 2'd1;
    localparam t_status STAT_EXHAUSTED = 2'd2;

    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = 25'd65536;

endpackage

// ----- hw/rtl/fpls_if.sv -----
// ----------------------------------------------------------------------------
// fpls_if
// request and response channels of the fenced page suballocator
// ----------------------------------------------------------------------------
interface fpls_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [fpls_pkg::SIZE_W-1:0]         size_bytes;
    logic [fpls_pkg::ALOG_W-1:0]         align_log2;
    logic [fpls_pkg::FENCE_IN_W-1:0]     fence_value;
    logic [fpls_pkg::FENCE_IN_W-1:0]     completed_fence;

    modport source (
        output valid, command, size_bytes, align_log2, fence_value, completed_fence,
        input  ready
    );
    modport sink (
        input  valid, command, size_bytes, align_log2, fence_value, completed_fence,
        output ready
    );
endinterface

interface fpls_rsp_if;
    logic                                valid;
    logic                                ready;
    fpls_pkg::t_status                   status;
    logic [fpls_pkg::PAGE_ID_W-1:0]      page_id;
    logic [fpls_pkg::PSIZE_W-1:0]        page_offset;
    logic [fpls_pkg::ASIZE_W-1:0]        aligned_size;
    logic                                new_page;

    modport source (
        output valid, status, page_id, page_offset, aligned_size, new_page,
        input  ready
    );
    modport sink (
        input  valid, status, page_id, page_offset, aligned_size, new_page,
        output ready
    );
endinterface

// ----- hw/rtl/fpls_ram.sv -----
// ----------------------------------------------------------------------------
// fpls_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fpls_ram #(
    parameter  int unsigned WIDTH  = 8,
    parameter  int unsigned DEPTH  = 64,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fenced_page_linear_suballocator_top.sv -----
// ----------------------------------------------------------------------------
// fenced_page_linear_suballocator_top
// bump suballocator over fixed-size pages with fence-gated page recycling.
// each request word returns one response word. an allocate rounds the size
// up to its alignment, aligns the bump offset and serves from the current
// page; a request larger than page_size returns status too-large. when the
// current page is missing or overflows, fence-completed pages at the head
// of the fenced queue are drained to the available queue, a new page is
// popped from there or freshly numbered, and the old page is retired to
// the local list as the new one is installed (status exhausted, old page
// kept, when all MAX_PAGES exist). a cleanup moves the current page and the
// local list into the fenced queue tagged with fence_value. all three page
// queues share one ring memory (available | fenced | local, in order) plus
// a fence tag memory, both with registered reads; no clearing pass is
// needed after reset. the drain walk is bound by the fence memory read
// latency: each fenced head is read, then checked, before the next one. the
// response sits in an output register, so a stalled sink only holds the
// block once the next response is ready.
// ----------------------------------------------------------------------------
`include "fenced_page_linear_suballocator_top_assert.svh"

module fenced_page_linear_suballocator_top #(
    parameter int unsigned MAX_PAGES  = 64,
    parameter int unsigned FENCE_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fpls_req_if.sink                       i_req,
    fpls_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [fpls_pkg::PSIZE_W-1:0]   i_cfg_wdata
);

    // page number and queue count widths
    localparam int unsigned PAGE_W = $clog2(MAX_PAGES);
    localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);

    localparam int unsigned PS_W = fpls_pkg::PSIZE_W;
    localparam int unsigned AS_W = fpls_pkg::ASIZE_W;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CALC      = 4'd1;
    localparam logic [3:0] S_FIT       = 4'd2;
    localparam logic [3:0] S_DRAIN_RD  = 4'd3;
    localparam logic [3:0] S_DRAIN_CHK = 4'd4;
    localparam logic [3:0] S_TAKE      = 4'd5;
    localparam logic [3:0] S_POP       = 4'd6;
    localparam logic [3:0] S_CLEAN     = 4'd7;
    localparam logic [3:0] S_SWEEP     = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    // ring pointer advance with wrap at MAX_PAGES
    function automatic logic [PAGE_W-1:0] ptr_inc(input logic [PAGE_W-1:0] p);
        return (p == PAGE_W'(MAX_PAGES - 1)) ? '0 : p + PAGE_W'(1);
    endfunction

    // control state
    logic [3:0]          r_state,     n_state;
    logic [PS_W-1:0]     r_page_size, n_page_size;
    logic                r_cur_valid, n_cur_valid;
    logic [PAGE_W-1:0]   r_cur_page,  n_cur_page;
    logic [PS_W-1:0]     r_cur_off,   n_cur_off;
    // ring: [head, fhead) available, [fhead, lhead) fenced, [lhead, tail) local
    logic [PAGE_W-1:0]   r_head,  n_head;
    logic [PAGE_W-1:0]   r_fhead, n_fhead;
    logic [PAGE_W-1:0]   r_lhead, n_lhead;
    logic [PAGE_W-1:0]   r_tail,  n_tail;
    logic [CNT_W-1:0]    r_avail_cnt, n_avail_cnt;
    logic [CNT_W-1:0]    r_fen_cnt,   n_fen_cnt;
    logic [CNT_W-1:0]    r_loc_cnt,   n_loc_cnt;
    logic [CNT_W-1:0]    r_created,   n_created;
    logic                r_out_valid, n_out_valid;

    // item and working registers
    logic [fpls_pkg::SIZE_W-1:0] r_size,  n_size;
    logic [fpls_pkg::ALOG_W-1:0] r_alog,  n_alog;
    logic [FENCE_BITS-1:0]   r_fence,     n_fence;
    logic [FENCE_BITS-1:0]   r_done_fence, n_done_fence;
    logic [AS_W-1:0]         r_asize,     n_asize;
    logic [AS_W-1:0]         r_off,       n_off;

    // staged response
    fpls_pkg::t_status       r_res_status, n_res_status;
    logic [PAGE_W-1:0]       r_res_page,   n_res_page;
    logic [PS_W-1:0]         r_res_offset, n_res_offset;
    logic                    r_res_new,    n_res_new;

    // output register
    fpls_pkg::t_status               r_out_status, n_out_status;
    logic [fpls_pkg::PAGE_ID_W-1:0]  r_out_page,   n_out_page;
    logic [PS_W-1:0]                 r_out_offset, n_out_offset;
    logic [AS_W-1:0]                 r_out_asize,  n_out_asize;
    logic                            r_out_new,    n_out_new;

    // datapath
    logic [fpls_pkg::SIZE_W-1:0] w_amask;
    logic [AS_W-1:0]             w_asize;
    logic [AS_W-1:0]             w_off;
    logic [AS_W:0]               w_end;
    logic                        w_too_large;
    logic                        w_overflow;
    logic                        w_in_take;
    logic                        w_out_free;
    logic                        w_take_fresh;
    logic                        w_install;
    logic [PAGE_W-1:0]           w_install_page;
    logic [PAGE_W+fpls_pkg::PAGE_ID_W-1:0] w_page_ext;
    logic [CNT_W+1:0]            w_held_sum;

    // memory ports
    logic                    w_ring_we;
    logic [PAGE_W-1:0]       w_ring_rdata;
    logic                    w_fence_we;
    logic [FENCE_BITS-1:0]   w_fence_rdata;

    // page ring: the three page queues in one circular buffer
    fpls_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_PAGES)
    ) u_page_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (r_tail),
        .i_wdata (r_cur_page),
        .i_raddr (r_head),
        .o_rdata (w_ring_rdata)
    );

    // fence tag per ring entry, written when a cleanup moves local pages
    fpls_ram #(
        .WIDTH (FENCE_BITS),
        .DEPTH (MAX_PAGES)
    ) u_fence_mem (
        .i_clk   (i_clk),
        .i_we    (w_fence_we),
        .i_waddr (r_lhead),
        .i_wdata (r_fence),
        .i_raddr (r_fhead),
        .o_rdata (w_fence_rdata)
    );

    // size and offset rounding, two parallel adds
    assign w_amask = (fpls_pkg::SIZE_W'(1) << r_alog) - fpls_pkg::SIZE_W'(1);
    assign w_asize = ({1'b0, r_size} + {1'b0, w_amask}) & ~{1'b0, w_amask};
    assign w_off   = ({{(AS_W - PS_W){1'b0}}, r_cur_off} + {1'b0, w_amask})
                   & ~{1'b0, w_amask};

    // fit checks against the page size
    assign w_end       = {1'b0, r_off} + {1'b0, r_asize};
    assign w_too_large = r_asize > {{(AS_W - PS_W){1'b0}}, r_page_size};
    assign w_overflow  = w_end > {{(AS_W + 1 - PS_W){1'b0}}, r_page_size};

    assign w_in_take    = i_req.valid && (r_state == S_IDLE);
    assign w_out_free   = !r_out_valid || o_rsp.ready;

    // a new page comes either from the ring head or from the fresh counter
    assign w_take_fresh = (r_state == S_TAKE) && (r_avail_cnt == '0)
                       && (r_created < CNT_W'(MAX_PAGES));
    assign w_install      = w_take_fresh || (r_state == S_POP);
    assign w_install_page = (r_state == S_POP) ? w_ring_rdata : r_created[PAGE_W-1:0];

    // retiring the current page always appends it at the ring tail
    assign w_ring_we  = r_cur_valid && (w_install || (r_state == S_CLEAN));
    assign w_fence_we = (r_state == S_SWEEP) && (r_loc_cnt != '0);

    assign w_page_ext = {{fpls_pkg::PAGE_ID_W{1'b0}}, r_res_page};

    always_comb begin
        n_state      = r_state;
        n_page_size  = i_cfg_we ? i_cfg_wdata : r_page_size;
        n_cur_valid  = r_cur_valid;
        n_cur_page   = r_cur_page;
        n_cur_off    = r_cur_off;
        n_head       = r_head;
        n_fhead      = r_fhead;
        n_lhead      = r_lhead;
        n_tail       = r_tail;
        n_avail_cnt  = r_avail_cnt;
        n_fen_cnt    = r_fen_cnt;
        n_loc_cnt    = r_loc_cnt;
        n_created    = r_created;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_size       = r_size;
        n_alog       = r_alog;
        n_fence      = r_fence;
        n_done_fence = r_done_fence;
        n_asize      = r_asize;
        n_off        = r_off;
        n_res_status = r_res_status;
        n_res_page   = r_res_page;
        n_res_offset = r_res_offset;
        n_res_new    = r_res_new;
        n_out_status = r_out_status;
        n_out_page   = r_out_page;
        n_out_offset = r_out_offset;
        n_out_asize  = r_out_asize;
        n_out_new    = r_out_new;

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_size       = i_req.size_bytes;
                    n_alog       = i_req.align_log2;
                    n_fence      = i_req.fence_value[FENCE_BITS-1:0];
                    n_done_fence = i_req.completed_fence[FENCE_BITS-1:0];
                    // cleanup words answer with all fields zero
                    n_res_status = fpls_pkg::STAT_OK;
                    n_res_page   = '0;
                    n_res_offset = '0;
                    n_res_new    = 1'b0;
                    n_asize      = '0;
                    n_state      = (i_req.command == fpls_pkg::CMD_CLEANUP) ? S_CLEAN : S_CALC;
                end
            end
            S_CALC: begin
                n_asize = w_asize;
                n_off   = w_off;
                n_state = S_FIT;
            end
            S_FIT: begin
                if (w_too_large) begin
                    // too large: no state change
                    n_res_status = fpls_pkg::STAT_TOO_LARGE;
                    n_state      = S_OUT;
                end else if (!r_cur_valid || w_overflow) begin
                    n_state = S_DRAIN_RD;
                end else begin
                    n_res_page   = r_cur_page;
                    n_res_offset = r_off[PS_W-1:0];
                    n_cur_off    = w_end[PS_W-1:0];
                    n_state      = S_OUT;
                end
            end
            S_DRAIN_RD: begin
                // fence memory is reading the fenced head this cycle
                n_state = (r_fen_cnt == '0) ? S_TAKE : S_DRAIN_CHK;
            end
            S_DRAIN_CHK: begin
                if (w_fence_rdata <= r_done_fence) begin
                    // completed: head entry joins the available region
                    n_fhead     = ptr_inc(r_fhead);
                    n_fen_cnt   = r_fen_cnt - CNT_W'(1);
                    n_avail_cnt = r_avail_cnt + CNT_W'(1);
                    n_state     = S_DRAIN_RD;
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                if (r_avail_cnt != '0) begin
                    n_state = S_POP;
                end else if (w_take_fresh) begin
                    n_created = r_created + CNT_W'(1);
                    n_state   = S_OUT;
                end else begin
                    // pool exhausted: current page stays as it was
                    n_res_status = fpls_pkg::STAT_EXHAUSTED;
                    n_state      = S_OUT;
                end
            end
            S_POP: begin
                n_head      = ptr_inc(r_head);
                n_avail_cnt = r_avail_cnt - CNT_W'(1);
                n_state     = S_OUT;
            end
            S_CLEAN: begin
                if (r_cur_valid) begin
                    n_cur_valid = 1'b0;
                    n_cur_off   = '0;
                    n_tail      = ptr_inc(r_tail);
                    n_loc_cnt   = r_loc_cnt + CNT_W'(1);
                end
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                // tag one local page a cycle, then the boundary moves past it
                if (r_loc_cnt != '0) begin
                    n_lhead   = ptr_inc(r_lhead);
                    n_loc_cnt = r_loc_cnt - CNT_W'(1);
                    n_fen_cnt = r_fen_cnt + CNT_W'(1);
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_page   = w_page_ext[fpls_pkg::PAGE_ID_W-1:0];
                    n_out_offset = r_res_offset;
                    n_out_asize  = r_asize;
                    n_out_new    = r_res_new;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // page switch: retire the current page, then take the new one
        if (w_install) begin
            if (r_cur_valid) begin
                n_tail    = ptr_inc(r_tail);
                n_loc_cnt = r_loc_cnt + CNT_W'(1);
            end
            n_cur_valid  = 1'b1;
            n_cur_page   = w_install_page;
            n_cur_off    = r_asize[PS_W-1:0];
            n_res_page   = w_install_page;
            n_res_offset = '0;
            n_res_new    = w_take_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_page_size <= fpls_pkg::PAGE_SIZE_RST;
            r_cur_valid <= 1'b0;
            r_cur_page  <= '0;
            r_cur_off   <= '0;
            r_head      <= '0;
            r_fhead     <= '0;
            r_lhead     <= '0;
            r_tail      <= '0;
            r_avail_cnt <= '0;
            r_fen_cnt   <= '0;
            r_loc_cnt   <= '0;
            r_created   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_page_size <= n_page_size;
            r_cur_valid <= n_cur_valid;
            r_cur_page  <= n_cur_page;
            r_cur_off   <= n_cur_off;
            r_head      <= n_head;
            r_fhead     <= n_fhead;
            r_lhead     <= n_lhead;
            r_tail      <= n_tail;
            r_avail_cnt <= n_avail_cnt;
            r_fen_cnt   <= n_fen_cnt;
            r_loc_cnt   <= n_loc_cnt;
            r_created   <= n_created;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size       <= n_size;
        r_alog       <= n_alog;
        r_fence      <= n_fence;
        r_done_fence <= n_done_fence;
        r_asize      <= n_asize;
        r_off        <= n_off;
        r_res_status <= n_res_status;
        r_res_page   <= n_res_page;
        r_res_offset <= n_res_offset;
        r_res_new    <= n_res_new;
        r_out_status <= n_out_status;
        r_out_page   <= n_out_page;
        r_out_offset <= n_out_offset;
        r_out_asize  <= n_out_asize;
        r_out_new    <= n_out_new;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.page_id      = r_out_page;
    assign o_rsp.page_offset  = r_out_offset;
    assign o_rsp.aligned_size = r_out_asize;
    assign o_rsp.new_page     = r_out_new;

    // every numbered page is either current or held in exactly one ring region
    assign w_held_sum = (CNT_W + 2)'(r_avail_cnt) + (CNT_W + 2)'(r_fen_cnt)
                      + (CNT_W + 2)'(r_loc_cnt) + (CNT_W + 2)'(r_cur_valid);

    `FPLS_CHECK(a_pages_conserved, 1'b1, w_held_sum == (CNT_W + 2)'(r_created), "page lost or duplicated")
    `FPLS_CHECK(a_pop_nonempty, r_state == S_POP, r_avail_cnt != '0, "pop from empty available region")
    `FPLS_CHECK_NEXT(a_accept_busy, i_req.valid && i_req.ready, r_state != S_IDLE, "accepted word not processed")

endmodule
